[rtl/core/lpp_pkg.sv]
// shared types, constants and width helpers for the line perspective projector
// used by lpp_proj and line_perspective_projector_top
package lpp_pkg;

    localparam int OUT_W   = 18;
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;
    localparam int CFG_IW  = 4;
    localparam int CFG_DW  = 20;
    localparam int SIZE_W  = 19;
    localparam int OFF_W   = 20;

    localparam int DEF_LINE_COUNT = 256;
    localparam int DEF_COORD_BITS = 20;

    localparam logic signed [OFF_W-1:0] RST_NEAR  = OFF_W'(0);
    localparam logic [SIZE_W-1:0]       RST_VOL   = SIZE_W'(4000);
    localparam logic signed [OFF_W-1:0] RST_WOFF  = OFF_W'(-160);
    localparam logic [SIZE_W-1:0]       RST_WSIZE = SIZE_W'(320);

    typedef enum logic [CFG_IW-1:0] {
        REG_NEAR_Z        = 4'd0,
        REG_VOLUME_WIDTH  = 4'd1,
        REG_VOLUME_HEIGHT = 4'd2,
        REG_VOLUME_DEPTH  = 4'd3,
        REG_WINDOW_LEFT   = 4'd4,
        REG_WINDOW_BOTTOM = 4'd5,
        REG_WINDOW_WIDTH  = 4'd6,
        REG_WINDOW_HEIGHT = 4'd7
    } t_cfg_reg;

    // widths along the projection pipeline
    function automatic int lpp_cw(input int cb);
        return cb + 1;
    endfunction

    function automatic int lpp_zw(input int cb);
        return ((cb + 1 > OFF_W) ? cb + 1 : OFF_W) + 1;
    endfunction

    function automatic int lpp_p1w(input int cb);
        return cb + 1 + OFF_W;
    endfunction

    function automatic int lpp_pw(input int cb);
        return lpp_p1w(cb) + 3 + lpp_zw(cb);
    endfunction

    // register stages from the input ports to the projected coordinate
    function automatic int lpp_latency(input int cb);
        return 10 + lpp_p1w(cb) + lpp_pw(cb);
    endfunction

endpackage

[rtl/core/lpp_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module lpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/lpp_proj.sv]
// projection of one coordinate onto its screen axis, fully pipelined
// two bit-per-stage dividers; depends on lpp_pkg
module lpp_proj import lpp_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic signed [COORD_BITS-1:0] i_coord,
    input  logic signed [COORD_BITS-1:0] i_eye,
    input  logic signed [COORD_BITS-1:0] i_z,
    input  logic signed [COORD_BITS-1:0] i_eye_z,
    input  logic signed [OFF_W-1:0]      i_near,
    input  logic [SIZE_W-1:0]            i_vsize,
    input  logic [SIZE_W-1:0]            i_vdepth,
    input  logic [SIZE_W-1:0]            i_wsize,
    input  logic signed [OFF_W-1:0]      i_woff,
    output logic signed [OUT_W-1:0]      o_pos
);

    localparam int CW  = lpp_cw(COORD_BITS);
    localparam int ZW  = lpp_zw(COORD_BITS);
    localparam int P1W = lpp_p1w(COORD_BITS);
    localparam int DW  = P1W + 3;
    localparam int LO  = DW / 2;
    localparam int HI  = DW - LO;
    localparam int PW  = lpp_pw(COORD_BITS);
    localparam int VW  = PW + 2;
    localparam logic signed [VW-1:0] SAT_HI = VW'(OUT_MAX);
    localparam logic signed [VW-1:0] SAT_LO = VW'(OUT_MIN);

    // entry and first product
    logic signed [CW-1:0]  r_c0, r_cA;
    logic signed [ZW-1:0]  r_z0, r_zA;
    logic signed [P1W-1:0] r_p1;

    always_ff @(posedge i_clk) begin
        r_c0 <= CW'(i_coord) - CW'(i_eye);
        r_z0 <= ZW'(i_z) - ZW'(i_eye_z) - ZW'(i_near);
        r_p1 <= r_c0 * $signed({1'b0, i_wsize});
        r_cA <= r_c0;
        r_zA <= r_z0;
    end

    // first divider: |c * wsize| / vsize
    logic [SIZE_W-1:0]    r_rem1 [P1W+1];
    logic [P1W-1:0]       r_num1 [P1W+1];
    logic                 r_sg1  [P1W+1];
    logic signed [CW-1:0] r_c1   [P1W+1];
    logic signed [ZW-1:0] r_z1   [P1W+1];

    always_ff @(posedge i_clk) begin
        r_rem1[0] <= '0;
        r_num1[0] <= r_p1[P1W-1] ? P1W'(-r_p1) : P1W'(r_p1);
        r_sg1[0]  <= r_p1[P1W-1];
        r_c1[0]   <= r_cA;
        r_z1[0]   <= r_zA;
    end

    for (genvar k = 0; k < P1W; k++) begin : g_div1
        logic [SIZE_W:0] cand;
        logic            ge;
        assign cand = {r_rem1[k], r_num1[k][P1W-1]};
        assign ge   = cand >= {1'b0, i_vsize};
        always_ff @(posedge i_clk) begin
            r_rem1[k+1] <= ge ? SIZE_W'(cand - {1'b0, i_vsize}) : cand[SIZE_W-1:0];
            r_num1[k+1] <= {r_num1[k][P1W-2:0], ge};
            r_sg1[k+1]  <= r_sg1[k];
            r_c1[k+1]   <= r_c1[k];
            r_z1[k+1]   <= r_z1[k];
        end
    end

    // window offset, difference, split second product, sum
    logic signed [P1W:0]      q1s;
    logic signed [P1W+1:0]    r_t;
    logic signed [DW-1:0]     r_d;
    logic signed [LO+ZW:0]    r_plo;
    logic signed [HI+ZW-1:0]  r_phi;
    logic signed [PW-1:0]     r_p2;
    logic signed [CW-1:0]     r_cC, r_cD, r_cE, r_cF;
    logic signed [ZW-1:0]     r_zC, r_zD;

    assign q1s = r_sg1[P1W] ? -$signed({1'b0, r_num1[P1W]}) : $signed({1'b0, r_num1[P1W]});

    always_ff @(posedge i_clk) begin
        r_t   <= (P1W+2)'(q1s) + (P1W+2)'(i_woff);
        r_cC  <= r_c1[P1W];
        r_zC  <= r_z1[P1W];
        r_d   <= DW'(r_t) - DW'(r_cC);
        r_cD  <= r_cC;
        r_zD  <= r_zC;
        r_plo <= $signed({1'b0, r_d[LO-1:0]}) * r_zD;
        r_phi <= $signed(r_d[DW-1:LO]) * r_zD;
        r_cE  <= r_cD;
        r_p2  <= (PW'(r_phi) <<< LO) + PW'(r_plo);
        r_cF  <= r_cE;
    end

    // second divider: |(t - c) * dz| / vdepth
    logic [SIZE_W-1:0]    r_rem2 [PW+1];
    logic [PW-1:0]        r_num2 [PW+1];
    logic                 r_sg2  [PW+1];
    logic signed [CW-1:0] r_c2   [PW+1];

    always_ff @(posedge i_clk) begin
        r_rem2[0] <= '0;
        r_num2[0] <= r_p2[PW-1] ? PW'(-r_p2) : PW'(r_p2);
        r_sg2[0]  <= r_p2[PW-1];
        r_c2[0]   <= r_cF;
    end

    for (genvar k = 0; k < PW; k++) begin : g_div2
        logic [SIZE_W:0] cand;
        logic            ge;
        assign cand = {r_rem2[k], r_num2[k][PW-1]};
        assign ge   = cand >= {1'b0, i_vdepth};
        always_ff @(posedge i_clk) begin
            r_rem2[k+1] <= ge ? SIZE_W'(cand - {1'b0, i_vdepth}) : cand[SIZE_W-1:0];
            r_num2[k+1] <= {r_num2[k][PW-2:0], ge};
            r_sg2[k+1]  <= r_sg2[k];
            r_c2[k+1]   <= r_c2[k];
        end
    end

    // recenter, floor shift by two, saturate
    logic signed [PW:0]   q2s;
    logic signed [VW-1:0] r_v;
    logic signed [VW-1:0] sh;

    assign q2s = r_sg2[PW] ? -$signed({1'b0, r_num2[PW]}) : $signed({1'b0, r_num2[PW]});
    assign sh  = r_v >>> 2;

    always_ff @(posedge i_clk) begin
        r_v <= VW'(q2s) + VW'(r_c2[PW]) + VW'($signed({1'b0, i_vsize[SIZE_W-1:1]}));
        if (sh > SAT_HI) begin
            o_pos <= OUT_W'(SAT_HI);
        end else if (sh < SAT_LO) begin
            o_pos <= OUT_W'(SAT_LO);
        end else begin
            o_pos <= OUT_W'(sh);
        end
    end

endmodule

[rtl/core/line_perspective_projector_top.sv]
// top level of the line perspective projector: config registers, four
// coordinate pipelines and the screen line ram; depends on lpp_pkg, lpp_proj, lpp_ram
//
//  channel   handshake                      payload
//  input     start & !busy                  i_line_index, i_start_*, i_end_*, i_eye_*
//  result    o_result_valid (one cycle)     o_moved, o_old_*, o_new_*
//  config    i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
//
// one item per cycle while busy is low; each result strobe follows its accept through
// the lpp_proj pipelines, two bit-per-stage dividers each, and the output register.
// after reset the ram is cleared one entry a cycle, entries 0 to LINE_COUNT-1, busy high.
// a repeated index one item apart is served from a forwarding register.
// results cannot be stalled; config is always ready.
module line_perspective_projector_top import lpp_pkg::*; #(
    parameter int LINE_COUNT = DEF_LINE_COUNT,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   i_line_index,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_start_z,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_end_z,
    input  logic signed [COORD_BITS-1:0] i_eye_x,
    input  logic signed [COORD_BITS-1:0] i_eye_y,
    input  logic signed [COORD_BITS-1:0] i_eye_z,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IW-1:0]            i_cfg_index,
    input  logic [CFG_DW-1:0]            i_cfg_data,
    output logic                         o_result_valid,
    output logic                         o_moved,
    output logic signed [OUT_W-1:0]      o_old_start_x,
    output logic signed [OUT_W-1:0]      o_old_start_y,
    output logic signed [OUT_W-1:0]      o_old_end_x,
    output logic signed [OUT_W-1:0]      o_old_end_y,
    output logic signed [OUT_W-1:0]      o_new_start_x,
    output logic signed [OUT_W-1:0]      o_new_start_y,
    output logic signed [OUT_W-1:0]      o_new_end_x,
    output logic signed [OUT_W-1:0]      o_new_end_y
);

    localparam int LAT   = lpp_latency(COORD_BITS);
    localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int EW    = 4 * OUT_W;

    // configuration registers
    logic signed [OFF_W-1:0] r_near, r_wleft, r_wbottom;
    logic [SIZE_W-1:0]       r_vwidth, r_vheight, r_vdepth, r_wwidth, r_wheight;
    logic [SIZE_W-1:0]       vw_nz, vh_nz, vd_nz;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near    <= RST_NEAR;
            r_vwidth  <= RST_VOL;
            r_vheight <= RST_VOL;
            r_vdepth  <= RST_VOL;
            r_wleft   <= RST_WOFF;
            r_wbottom <= RST_WOFF;
            r_wwidth  <= RST_WSIZE;
            r_wheight <= RST_WSIZE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_NEAR_Z:        r_near    <= i_cfg_data;
                REG_VOLUME_WIDTH:  r_vwidth  <= i_cfg_data[SIZE_W-1:0];
                REG_VOLUME_HEIGHT: r_vheight <= i_cfg_data[SIZE_W-1:0];
                REG_VOLUME_DEPTH:  r_vdepth  <= i_cfg_data[SIZE_W-1:0];
                REG_WINDOW_LEFT:   r_wleft   <= i_cfg_data;
                REG_WINDOW_BOTTOM: r_wbottom <= i_cfg_data;
                REG_WINDOW_WIDTH:  r_wwidth  <= i_cfg_data[SIZE_W-1:0];
                REG_WINDOW_HEIGHT: r_wheight <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero divisor acts as one
    assign vw_nz = (r_vwidth == '0)  ? SIZE_W'(1) : r_vwidth;
    assign vh_nz = (r_vheight == '0) ? SIZE_W'(1) : r_vheight;
    assign vd_nz = (r_vdepth == '0)  ? SIZE_W'(1) : r_vdepth;

    // ram clearing pass after reset
    logic             r_clr;
    logic [IDX_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(LINE_COUNT - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign busy = r_clr;

    // line index modulo LINE_COUNT by compare and subtract
    function automatic logic [IDX_W-1:0] wrap_index(input logic [7:0] v);
        logic [7:0] rem;
        rem = v;
        for (int s = 7; s >= 0; s--) begin
            if ((LINE_COUNT << s) <= 255) begin
                if (rem >= 8'(LINE_COUNT << s)) begin
                    rem = rem - 8'(LINE_COUNT << s);
                end
            end
        end
        return IDX_W'(rem);
    endfunction

    // item tracking along the pipeline
    logic             acc;
    logic [IDX_W-1:0] idx_in;
    logic             r_vld [LAT];
    logic [IDX_W-1:0] r_idx [LAT];

    assign acc    = start && !busy;
    assign idx_in = wrap_index(i_line_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= acc;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx[0] <= idx_in;
        for (int k = 1; k < LAT; k++) begin
            r_idx[k] <= r_idx[k-1];
        end
    end

    // coordinate pipelines
    logic signed [OUT_W-1:0] ns_x, ns_y, ne_x, ne_y;

    lpp_proj #(.COORD_BITS(COORD_BITS)) u_proj_sx (
        .i_clk(i_clk), .i_coord(i_start_x), .i_eye(i_eye_x), .i_z(i_start_z),
        .i_eye_z(i_eye_z), .i_near(r_near), .i_vsize(vw_nz), .i_vdepth(vd_nz),
        .i_wsize(r_wwidth), .i_woff(r_wleft), .o_pos(ns_x)
    );
    lpp_proj #(.COORD_BITS(COORD_BITS)) u_proj_sy (
        .i_clk(i_clk), .i_coord(i_start_y), .i_eye(i_eye_y), .i_z(i_start_z),
        .i_eye_z(i_eye_z), .i_near(r_near), .i_vsize(vh_nz), .i_vdepth(vd_nz),
        .i_wsize(r_wheight), .i_woff(r_wbottom), .o_pos(ns_y)
    );
    lpp_proj #(.COORD_BITS(COORD_BITS)) u_proj_ex (
        .i_clk(i_clk), .i_coord(i_end_x), .i_eye(i_eye_x), .i_z(i_end_z),
        .i_eye_z(i_eye_z), .i_near(r_near), .i_vsize(vw_nz), .i_vdepth(vd_nz),
        .i_wsize(r_wwidth), .i_woff(r_wleft), .o_pos(ne_x)
    );
    lpp_proj #(.COORD_BITS(COORD_BITS)) u_proj_ey (
        .i_clk(i_clk), .i_coord(i_end_y), .i_eye(i_eye_y), .i_z(i_end_z),
        .i_eye_z(i_eye_z), .i_near(r_near), .i_vsize(vh_nz), .i_vdepth(vd_nz),
        .i_wsize(r_wheight), .i_woff(r_wbottom), .o_pos(ne_y)
    );

    // screen line ram: read from the next-to-last tracking stage, write back in the last stage
    logic [EW-1:0] new_line, rdata, old_line, ram_wdata;
    logic          ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic          r_fwd;
    logic [EW-1:0] r_fwd_line;

    assign new_line  = {ns_x, ns_y, ne_x, ne_y};
    assign ram_we    = r_clr || r_vld[LAT-1];
    assign ram_waddr = r_clr ? r_clr_addr : r_idx[LAT-1];
    // an unmoved line writes back the same value, so every item writes
    assign ram_wdata = r_clr ? '0 : new_line;

    lpp_ram #(.WIDTH(EW), .DEPTH(LINE_COUNT)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(r_idx[LAT-2]), .o_rdata(rdata)
    );

    // the read misses a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= r_vld[LAT-1] && (r_idx[LAT-1] == r_idx[LAT-2]);
        end
        r_fwd_line <= new_line;
    end

    assign old_line = r_fwd ? r_fwd_line : rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_vld[LAT-1];
        end
        o_moved       <= old_line != new_line;
        o_old_start_x <= old_line[4*OUT_W-1:3*OUT_W];
        o_old_start_y <= old_line[3*OUT_W-1:2*OUT_W];
        o_old_end_x   <= old_line[2*OUT_W-1:OUT_W];
        o_old_end_y   <= old_line[OUT_W-1:0];
        o_new_start_x <= ns_x;
        o_new_start_y <= ns_y;
        o_new_end_x   <= ne_x;
        o_new_end_y   <= ne_y;
    end

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LAT + 1))
        else $error("result without a matching accepted item");

    a_fwd_needs_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(r_vld[LAT-1]))
        else $error("forwarding without a preceding write back");

    a_clear_full_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr) |-> $past(r_clr_addr) == IDX_W'(LINE_COUNT - 1))
        else $error("clearing pass ended early");

endmodule

[bench/tb_line_perspective_projector_top.sv]
// testbench for line_perspective_projector_top: directed and random 3d lines with
// a self-checking projection scoreboard; depends on lpp_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_line_perspective_projector_top;
    import lpp_pkg::*;

    localparam int CB = DEF_COORD_BITS;
    localparam int LATENCY = 130;
    localparam logic [CFG_IW-1:0] REG_SPARE = 4'hB;

    typedef struct {
        logic [7:0]           index;
        logic signed [CB-1:0] pt[9];   // start xyz, end xyz, eye xyz
    } t_line;

    typedef struct {
        logic                    moved;
        logic signed [OUT_W-1:0] crd[8];   // old sx sy ex ey, new sx sy ex ey
    } t_screen;

    class projection_scoreboard;
        t_screen  pending[$];
        longint   near_z, vol_w, vol_h, vol_d, win_l, win_b, win_w, win_h;
        longint   start_tbl[256][2];
        longint   end_tbl[256][2];
        int       errors;
        int       checked;
        int       moves;

        function new();
            near_z = 0; vol_w = 4000; vol_h = 4000; vol_d = 4000;
            win_l = -160; win_b = -160; win_w = 320; win_h = 320;
            foreach (start_tbl[i, j]) begin
                start_tbl[i][j] = 0;
                end_tbl[i][j]   = 0;
            end
            errors = 0; checked = 0; moves = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
            case (idx)
                REG_NEAR_Z:        near_z = longint'($signed(d));
                REG_VOLUME_WIDTH:  vol_w = d[SIZE_W-1:0];
                REG_VOLUME_HEIGHT: vol_h = d[SIZE_W-1:0];
                REG_VOLUME_DEPTH:  vol_d = d[SIZE_W-1:0];
                REG_WINDOW_LEFT:   win_l = longint'($signed(d));
                REG_WINDOW_BOTTOM: win_b = longint'($signed(d));
                REG_WINDOW_WIDTH:  win_w = d[SIZE_W-1:0];
                REG_WINDOW_HEIGHT: win_h = d[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // products stay below 2^62 at 20 bit coordinates, so no clamp is needed
        function longint project(longint c, longint z, longint vsize, longint wsize,
                                 longint woff);
            longint vs, vd, t, q, v;
            vs = (vsize == 0) ? 1 : vsize;
            vd = (vol_d == 0) ? 1 : vol_d;
            t  = (c * wsize) / vs + woff;
            q  = ((t - c) * (z - near_z)) / vd;
            v  = (q + c + (vs >>> 1)) >>> 2;
            if (v > OUT_MAX) v = OUT_MAX;
            if (v < OUT_MIN) v = OUT_MIN;
            return v;
        endfunction

        function void note_line(t_line it);
            longint  rel[6];
            longint  nw[4];
            t_screen s;
            int      k;
            k = int'(it.index);
            for (int i = 0; i < 6; i++)
                rel[i] = longint'(it.pt[i]) - longint'(it.pt[6 + i % 3]);
            nw[0] = project(rel[0], rel[2], vol_w, win_w, win_l);
            nw[1] = project(rel[1], rel[2], vol_h, win_h, win_b);
            nw[2] = project(rel[3], rel[5], vol_w, win_w, win_l);
            nw[3] = project(rel[4], rel[5], vol_h, win_h, win_b);
            s.crd[0] = OUT_W'(start_tbl[k][0]); s.crd[1] = OUT_W'(start_tbl[k][1]);
            s.crd[2] = OUT_W'(end_tbl[k][0]);   s.crd[3] = OUT_W'(end_tbl[k][1]);
            s.moved = 0;
            for (int i = 0; i < 4; i++) begin
                s.crd[4 + i] = OUT_W'(nw[i]);
                if (s.crd[i] != s.crd[4 + i]) s.moved = 1;
            end
            if (s.moved) begin
                start_tbl[k][0] = nw[0]; start_tbl[k][1] = nw[1];
                end_tbl[k][0]   = nw[2]; end_tbl[k][1]   = nw[3];
            end
            pending.push_back(s);
        endfunction

        function void check_result(t_screen got);
            string   names[8] = '{"old_start_x", "old_start_y", "old_end_x", "old_end_y",
                                  "new_start_x", "new_start_y", "new_end_x", "new_end_y"};
            t_screen exp_s;
            if (pending.size() == 0) begin
                $error("result strobe with nothing outstanding");
                errors++;
                return;
            end
            exp_s = pending.pop_front();
            checked++;
            if (exp_s.moved) moves++;
            if (got.moved !== exp_s.moved) begin
                $error("moved: expected %0d actual %0d", exp_s.moved, got.moved);
                errors++;
            end
            for (int i = 0; i < 8; i++)
                if (got.crd[i] !== exp_s.crd[i]) begin
                    $error("%s: expected %0d actual %0d", names[i], exp_s.crd[i], got.crd[i]);
                    errors++;
                end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [7:0]              i_line_index;
    logic signed [CB-1:0]    pt_drv[9];
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IW-1:0]       i_cfg_index;
    logic [CFG_DW-1:0]       i_cfg_data;
    logic                    o_result_valid;
    logic                    o_moved;
    logic signed [OUT_W-1:0] o_old_start_x, o_old_start_y, o_old_end_x, o_old_end_y;
    logic signed [OUT_W-1:0] o_new_start_x, o_new_start_y, o_new_end_x, o_new_end_y;

    projection_scoreboard board;
    t_line                last_line;
    int                   sent;

    line_perspective_projector_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_line_index(i_line_index),
        .i_start_x(pt_drv[0]), .i_start_y(pt_drv[1]), .i_start_z(pt_drv[2]),
        .i_end_x(pt_drv[3]), .i_end_y(pt_drv[4]), .i_end_z(pt_drv[5]),
        .i_eye_x(pt_drv[6]), .i_eye_y(pt_drv[7]), .i_eye_z(pt_drv[8]),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_moved(o_moved),
        .o_old_start_x(o_old_start_x), .o_old_start_y(o_old_start_y),
        .o_old_end_x(o_old_end_x), .o_old_end_y(o_old_end_y),
        .o_new_start_x(o_new_start_x), .o_new_start_y(o_new_start_y),
        .o_new_end_x(o_new_end_x), .o_new_end_y(o_new_end_y)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("line_perspective_projector_top: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        t_screen got;
        if (i_rst_n && o_result_valid) begin
            got.moved  = o_moved;
            got.crd[0] = o_old_start_x; got.crd[1] = o_old_start_y;
            got.crd[2] = o_old_end_x;   got.crd[3] = o_old_end_y;
            got.crd[4] = o_new_start_x; got.crd[5] = o_new_start_y;
            got.crd[6] = o_new_end_x;   got.crd[7] = o_new_end_y;
            board.check_result(got);
        end
    end

    // the wait with valid low after each write keeps valid from toggling twice in a step
    task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        board.write_reg(idx, d);
        @(posedge i_clk);
    endtask

    // mostly back to back, some short gaps, a few long ones
    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0) begin
            start <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_line(t_line it);
        start        <= 1;
        i_line_index <= it.index;
        for (int i = 0; i < 9; i++) pt_drv[i] <= it.pt[i];
        do @(posedge i_clk); while (busy);
        board.note_line(it);
        last_line = it;
        sent++;
        idle_gap();
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_line make_line(logic signed [CB-1:0] v, logic [7:0] idx);
        t_line it;
        it.index = idx;
        foreach (it.pt[i]) it.pt[i] = v;
        return it;
    endfunction

    function automatic t_line random_line();
        t_line it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 20) return last_line;   // same line again: nothing moves unless the settings changed since
        it.index = (r < 60) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        for (int i = 0; i < 9; i++)
            if (r % 3 == 0)
                it.pt[i] = CB'($urandom());
            else
                it.pt[i] = CB'($urandom_range(0, 8000) - 4000);
        if (r < 45) begin
            // usual scene: depth in front of the eye
            it.pt[2] = it.pt[8] + CB'($urandom_range(16, 60000));
            it.pt[5] = it.pt[8] + CB'($urandom_range(16, 60000));
        end
        return it;
    endfunction

    task automatic random_config();
        for (int k = 0; k <= REG_WINDOW_HEIGHT; k++) begin
            logic [CFG_DW-1:0] d;
            int r;
            r = $urandom_range(0, 9);
            if (k == REG_NEAR_Z || k == REG_WINDOW_LEFT || k == REG_WINDOW_BOTTOM)
                d = (r < 6) ? CFG_DW'($urandom_range(0, 2000) - 1000) : CFG_DW'($urandom());
            else
                d = (r == 0) ? '0 : (r < 7) ? CFG_DW'($urandom_range(1, 8000))
                                           : CFG_DW'($urandom_range(0, 524287));
            write_cfg(t_cfg_reg'(k), d);
        end
    endtask

    initial begin
        t_line it;
        board = new();
        sent = 0;
        i_rst_n = 0; start = 0; i_line_index = '0;
        foreach (pt_drv[i]) pt_drv[i] = '0;
        i_cfg_valid = 0; i_cfg_index = REG_NEAR_Z; i_cfg_data = '0;
        last_line = make_line('0, '0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, repeats and index reuse, back to back when no gap is drawn
        send_line(make_line('0, '0));
        send_line(make_line(20'sh7FFFF, 8'd255));
        send_line(make_line(-20'sh80000, 8'd1));
        it = make_line('0, 8'd2);
        it.pt[0] = 20'sh7FFFF; it.pt[3] = -20'sh80000; it.pt[2] = 20'sh7FFFF;
        it.pt[5] = -20'sh80000; it.pt[6] = -20'sh80000; it.pt[8] = -20'sh80000;
        send_line(it);
        send_line(it);
        it.pt[1] = 20'sh7FFFF; it.pt[4] = -20'sh80000;
        send_line(it);
        it = make_line('0, 8'd3);
        it.pt[0] = 20'sd100; it.pt[1] = -20'sd200; it.pt[2] = 20'sd5000;
        it.pt[5] = 20'sd9000;
        send_line(it);
        send_line(it);
        it.pt[0] = 20'sd101;
        send_line(it);
        drain();

        // extreme settings: zero divisors, largest sizes and offsets
        write_cfg(REG_VOLUME_WIDTH, '0);
        write_cfg(REG_VOLUME_HEIGHT, '0);
        write_cfg(REG_VOLUME_DEPTH, '0);
        write_cfg(REG_NEAR_Z, 20'h80000);
        write_cfg(REG_WINDOW_LEFT, 20'h7FFFF);
        write_cfg(REG_WINDOW_BOTTOM, 20'h80000);
        write_cfg(REG_WINDOW_WIDTH, 20'h7FFFF);
        write_cfg(REG_WINDOW_HEIGHT, '0);
        write_cfg(REG_SPARE, 20'h12345);
        send_line(make_line(20'sh7FFFF, 8'd4));
        send_line(make_line(-20'sh80000, 8'd4));
        it = make_line(20'sd1, 8'd5); it.pt[6] = '0; it.pt[7] = '0; it.pt[8] = '0;
        send_line(it);
        drain();
        write_cfg(REG_VOLUME_WIDTH, 20'h7FFFF);
        write_cfg(REG_VOLUME_HEIGHT, 20'h7FFFF);
        write_cfg(REG_VOLUME_DEPTH, 20'h7FFFF);
        write_cfg(REG_NEAR_Z, 20'h7FFFF);
        write_cfg(REG_WINDOW_LEFT, 20'h80000);
        write_cfg(REG_WINDOW_HEIGHT, 20'h7FFFF);
        send_line(make_line(20'sh7FFFF, 8'd6));
        send_line(make_line(-20'sh80000, 8'd6));
        it = make_line('0, 8'd7); it.pt[0] = -20'sh80000; it.pt[2] = 20'sh7FFFF;
        it.pt[8] = -20'sh80000;
        send_line(it);
        drain();

        // random phases under several settings, first at reset values
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                write_cfg(REG_NEAR_Z, RST_NEAR);
                write_cfg(REG_VOLUME_WIDTH, CFG_DW'(RST_VOL));
                write_cfg(REG_VOLUME_HEIGHT, CFG_DW'(RST_VOL));
                write_cfg(REG_VOLUME_DEPTH, CFG_DW'(RST_VOL));
                write_cfg(REG_WINDOW_LEFT, RST_WOFF);
                write_cfg(REG_WINDOW_BOTTOM, RST_WOFF);
                write_cfg(REG_WINDOW_WIDTH, CFG_DW'(RST_WSIZE));
                write_cfg(REG_WINDOW_HEIGHT, CFG_DW'(RST_WSIZE));
            end else
                random_config();
            repeat (222) send_line(random_line());
            drain();
        end

        $display("sent %0d lines over 8 register settings, %0d results checked, %0d moved",
                 sent, board.checked, board.moves);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("line_perspective_projector_top: match");
        else
            $display("line_perspective_projector_top: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/core/lpp_pkg.sv
rtl/core/lpp_ram.sv
rtl/core/lpp_proj.sv
rtl/core/line_perspective_projector_top.sv
bench/tb_line_perspective_projector_top.sv
